// ===== rtl/sorted_unique_key_set_top_defines.svh =====
// Assertion macros for the sorted unique key set
`ifndef SORTED_UNIQUE_KEY_SET_TOP_DEFINES_SVH
`define SORTED_UNIQUE_KEY_SET_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SUKS_ASSERT_SAME(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error("sorted unique key set check failed");
`define SUKS_ASSERT_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error("sorted unique key set check failed");
`else
`define SUKS_ASSERT_SAME(lbl, c, r, ante, cons)
`define SUKS_ASSERT_NEXT(lbl, c, r, ante, cons)
`endif

`endif

// ===== rtl/suks_pkg.sv =====
// Shared types and codes of the sorted unique key set
`default_nettype none
package suks_pkg;

  localparam int KEY_W = 32;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_DUMP      = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP,
    S_SPIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec_op;
    logic emit_empty;
    logic emit_key;
    logic rotate;
    logic idx_clr;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       count_zero;
    logic       slot_free;
    logic       emit_last;
    logic       spin_done;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/suks_ctrl.sv =====
// Controller state machine of the sorted unique key set
`default_nettype none
module suks_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  suks_pkg::stat_t  stat,
  output suks_pkg::cmd_t   cmd
);

  suks_pkg::state_t state;
  suks_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= suks_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      suks_pkg::S_IDLE: begin
        if (in_valid) state_next = suks_pkg::S_EXEC;
      end
      suks_pkg::S_EXEC: begin
        case (stat.func)
          suks_pkg::FUNC_INSERT, suks_pkg::FUNC_DELETE: begin
            if (stat.slot_free) state_next = suks_pkg::S_IDLE;
          end
          suks_pkg::FUNC_DUMP: begin
            if (stat.slot_free) begin
              state_next = stat.count_zero ? suks_pkg::S_IDLE : suks_pkg::S_DUMP;
            end
          end
          default: state_next = suks_pkg::S_IDLE;
        endcase
      end
      suks_pkg::S_DUMP: begin
        if (stat.slot_free && stat.emit_last) begin
          state_next = stat.spin_done ? suks_pkg::S_IDLE : suks_pkg::S_SPIN;
        end
      end
      suks_pkg::S_SPIN: begin
        if (stat.spin_done) state_next = suks_pkg::S_IDLE;
      end
      default: state_next = suks_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      suks_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      suks_pkg::S_EXEC: begin
        case (stat.func)
          suks_pkg::FUNC_INSERT, suks_pkg::FUNC_DELETE: begin
            cmd.exec_op = stat.slot_free;
          end
          suks_pkg::FUNC_DUMP: begin
            cmd.emit_empty = stat.slot_free && stat.count_zero;
            cmd.idx_clr    = 1'b1;
          end
          default: cmd = '0;
        endcase
      end
      suks_pkg::S_DUMP: begin
        cmd.emit_key = stat.slot_free;
        cmd.rotate   = stat.slot_free;
      end
      suks_pkg::S_SPIN: begin
        cmd.rotate = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/suks_dp.sv =====
// Datapath of the sorted unique key set: key cells, count, dump index, result register
`default_nettype none
`include "sorted_unique_key_set_top_defines.svh"
module suks_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        func,
  input  logic signed [suks_pkg::KEY_W-1:0] key,
  input  suks_pkg::cmd_t                    cmd,
  output suks_pkg::stat_t                   stat,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic signed [suks_pkg::KEY_W-1:0] value,
  output logic                              empty_res,
  output logic                              last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic signed [suks_pkg::KEY_W-1:0] key_slot [CAPACITY];
  logic [CW-1:0]                     count;
  logic [IW-1:0]                     idx;
  logic [1:0]                        op_func;
  logic signed [suks_pkg::KEY_W-1:0] op_key;

  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic                hit;
  logic                full;
  logic                do_ins;
  logic                do_del;
  logic                slot_free;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CW'(i) < count) && (key_slot[i] < op_key);
      eq[i] = (CW'(i) < count) && (key_slot[i] == op_key);
    end
  end

  assign hit       = |eq;
  assign full      = (count == CW'(CAPACITY));
  assign slot_free = !out_valid || !out_stall;
  assign do_ins    = cmd.exec_op && (op_func == suks_pkg::FUNC_INSERT) && !hit && !full;
  assign do_del    = cmd.exec_op && (op_func == suks_pkg::FUNC_DELETE) && hit;

  assign stat.func       = op_func;
  assign stat.count_zero = (count == '0);
  assign stat.slot_free  = slot_free;
  assign stat.emit_last  = (CW'(idx) == count - CW'(1));
  assign stat.spin_done  = (idx == IW'(CAPACITY - 1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func <= func;
      op_key  <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      if (!lt[0]) key_slot[0] <= op_key;
      for (int i = 1; i < CAPACITY; i++) begin
        if (!lt[i]) key_slot[i] <= lt[i-1] ? op_key : key_slot[i-1];
      end
    end else if (do_del) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (!lt[i]) key_slot[i] <= key_slot[i+1];
      end
    end else if (cmd.rotate) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        key_slot[i] <= key_slot[i+1];
      end
      key_slot[CAPACITY-1] <= key_slot[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (do_ins) count <= count + CW'(1);
      else if (do_del) count <= count - CW'(1);
      if (cmd.idx_clr) idx <= '0;
      else if (cmd.rotate) idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec_op || cmd.emit_empty || cmd.emit_key) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_op) begin
      value     <= op_key;
      empty_res <= 1'b0;
      last      <= 1'b1;
      if (op_func == suks_pkg::FUNC_INSERT) begin
        status <= hit ? suks_pkg::ST_DUPLICATE :
                  full ? suks_pkg::ST_FULL : suks_pkg::ST_INSERTED;
      end else begin
        status <= hit ? suks_pkg::ST_REMOVED : suks_pkg::ST_NOT_FOUND;
      end
    end else if (cmd.emit_empty) begin
      status    <= suks_pkg::ST_DUMP;
      value     <= '0;
      empty_res <= 1'b1;
      last      <= 1'b1;
    end else if (cmd.emit_key) begin
      status    <= suks_pkg::ST_DUMP;
      value     <= key_slot[0];
      empty_res <= 1'b0;
      last      <= stat.emit_last;
    end
  end

  `SUKS_ASSERT_SAME(a_count_range, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `SUKS_ASSERT_SAME(a_load_needs_slot, clk, rst, cmd.exec_op || cmd.emit_key, slot_free)
  `SUKS_ASSERT_SAME(a_emit_nonempty, clk, rst, cmd.emit_key, count != '0)
  `SUKS_ASSERT_NEXT(a_ins_grows, clk, rst, do_ins, count == $past(count) + CW'(1))

endmodule
`default_nettype wire

// ===== rtl/sorted_unique_key_set_top.sv =====
// Top level of the sorted unique key set
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | func, key
//   output  | out_valid | out_stall | status, value, empty_res, last
//
// Insert and delete: capture, then one compare-and-shift across all cells.
// Dump of a non-empty set: capture, setup, then one key per cycle from the head cell while
// the cell row rotates and the output does not stall, then the rest of a full rotation.
// Dump of an empty set and an unused func end after capture and execute; an unused func gives no result.
// Output stalls hold the dump stream and the pending result.
// rst is synchronous and empties the set.
`default_nettype none
module sorted_unique_key_set_top #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        func,
  input  logic signed [suks_pkg::KEY_W-1:0] key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        status,
  output logic signed [suks_pkg::KEY_W-1:0] value,
  output logic                              empty_res,
  output logic                              last
);

  suks_pkg::cmd_t  cmd;
  suks_pkg::stat_t stat;

  suks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  suks_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .key       (key),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value     (value),
    .empty_res (empty_res),
    .last      (last)
  );

endmodule
`default_nettype wire

// ===== verif/tb_sorted_unique_key_set_top.sv =====
// Self-checking testbench for the sorted unique key set: directed table, random traffic, fill and overflow
`timescale 1ns / 1ps
module tb_sorted_unique_key_set_top;

  localparam int CAP = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]        status;
    logic signed [31:0] value;
    logic              empty_res;
    logic              last;
  } key_result_t;

  typedef struct packed {
    logic [1:0]         f;
    logic signed [31:0] k;
    logic               typed;
    key_result_t        want;
  } op_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = suks_pkg::FUNC_INSERT;
  logic signed [31:0] key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic signed [31:0] value;
  logic empty_res;
  logic last;

  logic signed [31:0] stored_keys[$];
  key_result_t pending_results[$];
  int errors = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b0;
  bit quiet = 1'b0;

  localparam op_row_t DIRECTED_OPS [0:23] = '{
    '{suks_pkg::FUNC_DUMP,   32'sh0000_1234, 1'b1,
      '{suks_pkg::ST_DUMP, 32'sh0, 1'b1, 1'b1}},
    '{suks_pkg::FUNC_DELETE, 32'sh0000_0005, 1'b1,
      '{suks_pkg::ST_NOT_FOUND, 32'sh5, 1'b0, 1'b1}},
    '{FUNC_UNUSED,           32'shFFFF_FFFF, 1'b0, '0},
    '{suks_pkg::FUNC_INSERT, 32'sh7FFF_FFFF, 1'b1,
      '{suks_pkg::ST_INSERTED, 32'sh7FFF_FFFF, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_INSERT, 32'sh8000_0000, 1'b1,
      '{suks_pkg::ST_INSERTED, 32'sh8000_0000, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_INSERT, 32'sh0000_0000, 1'b1,
      '{suks_pkg::ST_INSERTED, 32'sh0, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_INSERT, 32'shFFFF_FFFF, 1'b1,
      '{suks_pkg::ST_INSERTED, 32'shFFFF_FFFF, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_INSERT, 32'sh0000_0001, 1'b1,
      '{suks_pkg::ST_INSERTED, 32'sh1, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_INSERT, 32'sh8000_0000, 1'b1,
      '{suks_pkg::ST_DUPLICATE, 32'sh8000_0000, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_INSERT, 32'sh7FFF_FFFF, 1'b1,
      '{suks_pkg::ST_DUPLICATE, 32'sh7FFF_FFFF, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DUMP,   32'sh0000_0000, 1'b0, '0},
    '{suks_pkg::FUNC_DELETE, 32'sh8000_0000, 1'b1,
      '{suks_pkg::ST_REMOVED, 32'sh8000_0000, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DELETE, 32'sh8000_0000, 1'b1,
      '{suks_pkg::ST_NOT_FOUND, 32'sh8000_0000, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DELETE, 32'sh7FFF_FFFF, 1'b1,
      '{suks_pkg::ST_REMOVED, 32'sh7FFF_FFFF, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DELETE, 32'sh0000_0000, 1'b1,
      '{suks_pkg::ST_REMOVED, 32'sh0, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DUMP,   32'shFFFF_FFFF, 1'b0, '0},
    '{FUNC_UNUSED,           32'sh0000_0000, 1'b0, '0},
    '{suks_pkg::FUNC_INSERT, 32'sh5555_5555, 1'b1,
      '{suks_pkg::ST_INSERTED, 32'sh5555_5555, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_INSERT, 32'shAAAA_AAAA, 1'b1,
      '{suks_pkg::ST_INSERTED, 32'shAAAA_AAAA, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DELETE, 32'shFFFF_FFFF, 1'b1,
      '{suks_pkg::ST_REMOVED, 32'shFFFF_FFFF, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DELETE, 32'sh0000_0001, 1'b1,
      '{suks_pkg::ST_REMOVED, 32'sh1, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DELETE, 32'sh5555_5555, 1'b1,
      '{suks_pkg::ST_REMOVED, 32'sh5555_5555, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DELETE, 32'shAAAA_AAAA, 1'b1,
      '{suks_pkg::ST_REMOVED, 32'shAAAA_AAAA, 1'b0, 1'b1}},
    '{suks_pkg::FUNC_DUMP,   32'shFFFF_FFFF, 1'b1,
      '{suks_pkg::ST_DUMP, 32'sh0, 1'b1, 1'b1}}
  };

  sorted_unique_key_set_top #(.CAPACITY(CAP)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value     (value),
    .empty_res (empty_res),
    .last      (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int lower_index(input logic signed [31:0] k);
    int i;
    i = 0;
    while (i < stored_keys.size() && stored_keys[i] < k) i++;
    return i;
  endfunction

  // Apply one accepted item to the shadow key set and queue its results.
  function automatic void update_key_set(input logic [1:0] f, input logic signed [31:0] k);
    int p;
    bit hit;
    p = lower_index(k);
    hit = (p < stored_keys.size()) && (stored_keys[p] == k);
    case (f)
      suks_pkg::FUNC_INSERT: begin
        if (hit) begin
          pending_results.push_back('{suks_pkg::ST_DUPLICATE, k, 1'b0, 1'b1});
        end else if (stored_keys.size() >= CAP) begin
          pending_results.push_back('{suks_pkg::ST_FULL, k, 1'b0, 1'b1});
        end else begin
          stored_keys.insert(p, k);
          pending_results.push_back('{suks_pkg::ST_INSERTED, k, 1'b0, 1'b1});
        end
      end
      suks_pkg::FUNC_DELETE: begin
        if (hit) begin
          stored_keys.delete(p);
          pending_results.push_back('{suks_pkg::ST_REMOVED, k, 1'b0, 1'b1});
        end else begin
          pending_results.push_back('{suks_pkg::ST_NOT_FOUND, k, 1'b0, 1'b1});
        end
      end
      suks_pkg::FUNC_DUMP: begin
        if (stored_keys.size() == 0) begin
          pending_results.push_back('{suks_pkg::ST_DUMP, 32'sh0, 1'b1, 1'b1});
        end else begin
          foreach (stored_keys[i]) begin
            pending_results.push_back('{suks_pkg::ST_DUMP, stored_keys[i], 1'b0,
                                        (i == stored_keys.size() - 1)});
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] f, input logic signed [31:0] k,
                           input logic typed = 1'b0, input key_result_t want = '0);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    key <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_key_set(f, k);
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] corner_keys [0:3];
    corner_keys = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'shFFFF_FFFF};
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 15)) - 8;
      2: return corner_keys[$urandom_range(0, 3)];
      default: begin
        if (stored_keys.size() == 0) return $urandom;
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end
    endcase
  endfunction

  task automatic send_mixed(input int count);
    int sent;
    int r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(FUNC_UNUSED, $urandom);
      end else begin
        if (r < 50) send_item(suks_pkg::FUNC_INSERT, pick_key());
        else if (r < 85) send_item(suks_pkg::FUNC_DELETE, pick_key());
        else send_item(suks_pkg::FUNC_DUMP, $urandom);
        sent++;
      end
    end
  endtask

  task automatic fill_and_overflow();
    logic signed [31:0] k;
    while (stored_keys.size() < CAP) begin
      if ($urandom_range(0, 7) == 0) send_item(suks_pkg::FUNC_INSERT, pick_key());
      else send_item(suks_pkg::FUNC_INSERT, $urandom);
    end
    do k = $urandom; while (lower_index(k) < CAP && stored_keys[lower_index(k)] == k);
    send_item(suks_pkg::FUNC_INSERT, k);
    send_item(suks_pkg::FUNC_INSERT, stored_keys[$urandom_range(0, CAP - 1)]);
    send_item(suks_pkg::FUNC_DUMP, $urandom);
    send_item(suks_pkg::FUNC_DELETE, stored_keys[0]);
    send_item(suks_pkg::FUNC_DELETE, stored_keys[stored_keys.size() - 1]);
    send_item(suks_pkg::FUNC_DELETE, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
    send_item(suks_pkg::FUNC_INSERT, k);
    send_item(suks_pkg::FUNC_DUMP, $urandom);
  endtask

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    key_result_t got;
    key_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, value, empty_res, last};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%0d empty_res=%0b last=%0b",
                 $time, got.status, got.value, got.empty_res, got.last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.value !== want.value ||
            got.empty_res !== want.empty_res || got.last !== want.last) begin
          $display("%0t: mismatch expected status=%0d value=%0d empty_res=%0b last=%0b",
                   $time, want.status, want.value, want.empty_res, want.last);
          $display("%0t:          actual   status=%0d value=%0d empty_res=%0b last=%0b",
                   $time, got.status, got.value, got.empty_res, got.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_unique_key_set_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_OPS[i]) begin
      send_item(DIRECTED_OPS[i].f, DIRECTED_OPS[i].k, DIRECTED_OPS[i].typed,
                DIRECTED_OPS[i].want);
    end

    idle_en = 1'b1;
    send_mixed(60);
    drain_results();

    idle_en = 1'b0;
    fill_and_overflow();

    idle_en = 1'b1;
    send_mixed(60);

    idle_en = 1'b0;
    quiet = 1'b1;
    send_mixed(15);

    drain_results();
    repeat (CAP + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: mismatch expected %0d more results, actual none",
               $time, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("sorted_unique_key_set_top verification clean");
    end else begin
      $display("sorted_unique_key_set_top verification failed");
    end
    $finish;
  end

endmodule
